### src/lrust_pkg.sv
// shared types, codes and defaults of the lru replacement with shift tracking unit
package lrust_pkg;

   localparam int DEF_SETS       = 1024;
   localparam int DEF_WAYS       = 16;
   localparam int DEF_STAMP_BITS = 32;

   localparam int FUNC_BITS     = 2;
   localparam int SET_IDX_BITS  = 10;
   localparam int WAY_IDX_BITS  = 4;
   localparam int KIND_BITS     = 3;
   localparam int POS_BITS      = 4;
   localparam int TOTAL_BITS    = 48;
   localparam int KIND_COUNT    = 5;

   localparam logic [FUNC_BITS-1:0] FUNC_VICTIM = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_FILL   = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_UPDATE = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_WRITE = 3'd3;

   typedef struct packed {
      logic [FUNC_BITS-1:0]    func;
      logic [SET_IDX_BITS-1:0] set_index;
      logic [WAY_IDX_BITS-1:0] way_index;
      logic [KIND_BITS-1:0]    access_kind;
      logic                    was_hit;
   } req_type;

   typedef struct packed {
      logic [WAY_IDX_BITS-1:0] victim_way;
      logic [POS_BITS-1:0]     shift_distance;
      logic [TOTAL_BITS-1:0]   hit_shift_total;
      logic [TOTAL_BITS-1:0]   miss_shift_total;
   } rsp_type;

endpackage

### src/lru_replacement_with_shift_tracking_unit.sv
// top level: timestamp lru replacement with per-set shift position tracking
//
// After reset the block runs a clearing pass over both set memories and takes no word
// until it ends. Each word then runs alone through the states in order: idle takes it,
// index reduces the set index and addresses the memories, exec receives the set row and
// track position and writes back what a fill or an update changes, and done hands the
// result to the output register once that register is free. A victim query adds the
// registered comparator tree over the ways of the row between exec and done. The next
// word is taken while a finished result still waits in the output register.
module lru_replacement_with_shift_tracking_unit #(
   parameter int SETS       = lrust_pkg::DEF_SETS,
   parameter int WAYS       = lrust_pkg::DEF_WAYS,
   parameter int STAMP_BITS = lrust_pkg::DEF_STAMP_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lrust_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lrust_pkg::rsp_type rsp_word
);

   import lrust_pkg::*;

   localparam int SET_BITS    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS    = $clog2(WAYS);
   localparam int LEVELS      = $clog2(WAYS);
   localparam int PAD_WAYS    = 2 ** LEVELS;
   localparam int LVL_BITS    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ROW_BITS    = WAYS * STAMP_BITS;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP       = (2 ** RECIP_SHIFT + SETS - 1) / SETS;
   localparam int PROD_BITS   = SET_IDX_BITS + RECIP_SHIFT + 1;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_INDEX = 6'b000100,
      ST_EXEC  = 6'b001000,
      ST_TREE  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic [STAMP_BITS-1:0] stamp;
      logic [WAY_BITS-1:0]   way;
   } cand_type;

   state_type               state_ff, state_in;
   logic [SET_BITS-1:0]     clear_ff, clear_in;
   req_type                 item_ff, item_in;
   logic [SET_IDX_BITS-1:0] quot_ff, quot_in;
   logic [SET_BITS-1:0]     set_ff, set_in;
   cand_type                cand_ff [PAD_WAYS];
   cand_type                cand_in [PAD_WAYS];
   logic [LVL_BITS-1:0]     level_ff, level_in;
   logic [POS_BITS-1:0]     dist_ff, dist_in;
   logic [STAMP_BITS-1:0]   counter_ff, counter_in;
   logic [TOTAL_BITS-1:0]   hit_ff [KIND_COUNT];
   logic [TOTAL_BITS-1:0]   hit_in [KIND_COUNT];
   logic [TOTAL_BITS-1:0]   miss_ff [KIND_COUNT];
   logic [TOTAL_BITS-1:0]   miss_in [KIND_COUNT];
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [PROD_BITS-1:0]    prod;
   logic [31:0]             rem_a;
   logic [31:0]             rem_b;
   logic [SET_BITS-1:0]     set_calc;

   logic                    row_we, row_re;
   logic [SET_BITS-1:0]     row_wa;
   logic [ROW_BITS-1:0]     row_wd, row_rd;
   logic [PAD_WAYS*STAMP_BITS-1:0] row_pad;
   logic                    pos_we;
   logic [POS_BITS-1:0]     pos_wd, pos_rd;

   logic                    way_ok;
   logic [WAY_BITS-1:0]     way_sel;
   logic [POS_BITS-1:0]     dist_calc;
   logic [TOTAL_BITS:0]     sum;
   logic [TOTAL_BITS-1:0]   hit_sel, miss_sel;

   lrust_ram #(.WIDTH(ROW_BITS), .DEPTH(SETS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_wa),
      .wr_data (row_wd),
      .rd_en   (row_re),
      .rd_addr (set_calc),
      .rd_data (row_rd)
   );

   lrust_ram #(.WIDTH(POS_BITS), .DEPTH(SETS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (row_wa),
      .wr_data (pos_wd),
      .rd_en   (row_re),
      .rd_addr (set_calc),
      .rd_data (pos_rd)
   );

   // set index modulo SETS by reciprocal multiply
   assign prod     = PROD_BITS'(req_word.set_index) * PROD_BITS'(RECIP);
   assign rem_a    = 32'(item_ff.set_index) - 32'(quot_ff) * 32'(SETS);
   assign rem_b    = (rem_a >= 32'(SETS)) ? (rem_a - 32'(SETS)) : rem_a;
   assign set_calc = SET_BITS'(rem_b);

   assign way_ok    = 32'(item_ff.way_index) < 32'(WAYS);
   assign way_sel   = WAY_BITS'(item_ff.way_index);
   assign dist_calc = (pos_rd >= item_ff.way_index) ? (pos_rd - item_ff.way_index)
                                                    : (item_ff.way_index - pos_rd);

   always_comb begin
      row_pad = '1;
      row_pad[ROW_BITS-1:0] = row_rd;
   end

   always_comb begin
      hit_sel  = '0;
      miss_sel = '0;
      for (int k = 0; k < KIND_COUNT; k++) begin
         if (item_ff.access_kind == KIND_BITS'(k)) begin
            hit_sel  = hit_ff[k];
            miss_sel = miss_ff[k];
         end
      end
   end

   assign sum = {1'b0, (item_ff.was_hit ? hit_sel : miss_sel)} + (TOTAL_BITS + 1)'(dist_calc);

   always_comb begin
      state_in     = state_ff;
      clear_in     = clear_ff;
      item_in      = item_ff;
      quot_in      = quot_ff;
      set_in       = set_ff;
      cand_in      = cand_ff;
      level_in     = level_ff;
      dist_in      = dist_ff;
      counter_in   = counter_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      row_we       = 1'b0;
      row_re       = 1'b0;
      row_wa       = set_ff;
      row_wd       = row_rd;
      pos_we       = 1'b0;
      pos_wd       = item_ff.way_index;

      unique case (state_ff)
         ST_CLEAR: begin
            row_we   = 1'b1;
            pos_we   = 1'b1;
            row_wa   = clear_ff;
            row_wd   = '0;
            pos_wd   = '0;
            clear_in = clear_ff + 1'b1;
            if (clear_ff == SET_BITS'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_word;
               quot_in  = SET_IDX_BITS'(prod >> RECIP_SHIFT);
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            set_in   = set_calc;
            row_re   = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            dist_in  = '0;
            state_in = ST_DONE;
            row_wd[way_sel*STAMP_BITS +: STAMP_BITS] = counter_ff;
            unique case (item_ff.func)
               FUNC_VICTIM: begin
                  for (int p = 0; p < PAD_WAYS; p++) begin
                     cand_in[p].stamp = row_pad[p*STAMP_BITS +: STAMP_BITS];
                     cand_in[p].way   = WAY_BITS'(p);
                  end
                  level_in = '0;
                  state_in = ST_TREE;
               end
               FUNC_FILL: begin
                  if (way_ok) begin
                     row_we = 1'b1;
                     if (counter_ff != '1) begin
                        counter_in = counter_ff + 1'b1;
                     end
                  end
               end
               FUNC_UPDATE: begin
                  if (way_ok) begin
                     dist_in = dist_calc;
                     pos_we  = 1'b1;
                     for (int k = 0; k < KIND_COUNT; k++) begin
                        if (item_ff.access_kind == KIND_BITS'(k)) begin
                           if (item_ff.was_hit) begin
                              hit_in[k] = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
                           end else begin
                              miss_in[k] = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
                           end
                        end
                     end
                     if (item_ff.was_hit && item_ff.access_kind != KIND_WRITE) begin
                        row_we = 1'b1;
                        if (counter_ff != '1) begin
                           counter_in = counter_ff + 1'b1;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_TREE: begin
            // ties keep the lower way
            for (int i = 0; i < PAD_WAYS / 2; i++) begin
               if (cand_ff[2*i+1].stamp < cand_ff[2*i].stamp) begin
                  cand_in[i] = cand_ff[2*i+1];
               end else begin
                  cand_in[i] = cand_ff[2*i];
               end
            end
            level_in = level_ff + 1'b1;
            if (level_ff == LVL_BITS'(LEVELS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_in.victim_way       = (item_ff.func == FUNC_VICTIM)
                                         ? WAY_IDX_BITS'(cand_ff[0].way) : '0;
               rsp_in.shift_distance   = dist_ff;
               rsp_in.hit_shift_total  = hit_sel;
               rsp_in.miss_shift_total = miss_sel;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < KIND_COUNT; k++) begin
            hit_ff[k]  <= '0;
            miss_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      quot_ff  <= quot_in;
      set_ff   <= set_in;
      cand_ff  <= cand_in;
      level_ff <= level_in;
      dist_ff  <= dist_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### src/lrust_ram.sv
// generic simple dual-port ram with registered read
module lrust_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
